// ===== rtl/core/dspt_pkg.sv =====
`default_nettype none
package dspt_pkg;

  localparam int COUNT_W   = 24;
  localparam int TARGET_W  = 13;
  localparam int ERR_W     = 25;
  localparam int INTEG_W   = 40;
  localparam int GAIN_W    = 16;
  localparam int MAXD_W    = 8;
  localparam int DRIVE_W   = 16;
  localparam int DEG_W     = 10;
  localparam int TICK_W    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [TICK_W-1:0]    TICK_LIMIT = 7'd110;
  localparam logic signed [DEG_W-1:0] WIDE_TURN = 10'sd110;
  localparam logic signed [ERR_W-1:0] DONE_BAND = 25'sd15;
  localparam logic signed [ERR_W-1:0] DEAD_BAND = 25'sd10;
  localparam logic signed [13:0]   TURN_SCALE = 14'sd4109;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_DEGREES = 3'd0,
    REG_MAX_DRIVE    = 3'd1,
    REG_KP_WIDE      = 3'd2,
    REG_KI_WIDE      = 3'd3,
    REG_KD_WIDE      = 3'd4,
    REG_KP_NARROW    = 3'd5,
    REG_KI_NARROW    = 3'd6,
    REG_KD_NARROW    = 3'd7
  } dspt_reg_t;

  // per-item control from the top level to each side
  typedef struct packed {
    logic start;
    logic step;
    logic load1;
    logic load2;
    logic load3;
    logic load4;
  } dspt_ctl_t;

  // degrees * 4109 / 1024, truncated toward zero
  function automatic logic signed [TARGET_W-1:0] turn_target(
    input logic signed [DEG_W-1:0] deg
  );
    logic signed [22:0] prod;
    logic signed [22:0] adj;
    begin
      prod = 23'(deg) * 23'(TURN_SCALE);
      adj  = prod[22] ? (prod + 23'sd1023) : prod;
      turn_target = adj[TARGET_W+9:10];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dspt_side.sv =====
`default_nettype none
module dspt_side import dspt_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dspt_ctl_t                  ctl,
  input  wire logic signed [TARGET_W-1:0] target,
  input  wire logic signed [COUNT_W-1:0]  count,
  input  wire logic [GAIN_W-1:0]          kp,
  input  wire logic [GAIN_W-1:0]          ki,
  input  wire logic [GAIN_W-1:0]          kd,
  input  wire logic [MAXD_W-1:0]          max_drive,
  output logic                            prev_small,
  output logic signed [DRIVE_W-1:0]       drive
);

  // a turn takes at most 109 steps of a 25-bit error, so the integral
  // never leaves 32 bits and only those bits reach the gain product
  localparam int IACC_W = 32;
  localparam int PE_W  = ERR_W + GAIN_W + 1;
  localparam int PI_W  = IACC_W + GAIN_W + 1;
  localparam int SUM_W = PI_W + 1;
  localparam int Q_W   = SUM_W - 12;

  // loop state
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [COUNT_W-1:0] last_r;

  // stage 1
  logic signed [ERR_W-1:0]   err1_r, der1_r;
  logic signed [IACC_W-1:0]  acc1_r;
  logic [GAIN_W-1:0]         kp1_r, ki1_r, kd1_r;
  logic [MAXD_W-1:0]         maxd1_r, maxd2_r, maxd3_r;
  logic                      zero1_r, zero2_r, zero3_r;
  // stage 2
  logic signed [PE_W-1:0]    pe2_r, pd2_r;
  logic signed [PI_W-1:0]    pi2_r;
  // stage 3
  logic signed [SUM_W-1:0]   sum3_r;
  // stage 4
  logic signed [DRIVE_W-1:0] drive_r;

  logic signed [ERR_W-1:0]   err_nxt, der_nxt;
  logic signed [INTEG_W:0]   acc_wide;
  logic signed [INTEG_W-1:0] acc_nxt;
  logic                      dead;
  logic signed [PE_W-1:0]    pe_nxt, pd_nxt;
  logic signed [PI_W-1:0]    pi_nxt;
  logic signed [SUM_W-1:0]   sum_nxt, sum_adj;
  logic signed [Q_W-1:0]     q;
  logic signed [DRIVE_W-1:0] drive_nxt;

  always_comb begin
    err_nxt  = ERR_W'(target) - ERR_W'(count);
    der_nxt  = ERR_W'(count) - ERR_W'(last_r);
    acc_wide = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(err_nxt);
    if (acc_wide[INTEG_W] != acc_wide[INTEG_W-1]) begin
      acc_nxt = acc_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                  : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_wide[INTEG_W-1:0];
    end
    dead = (err_nxt < DEAD_BAND) && (err_nxt > -DEAD_BAND);
    prev_small = (prev_err_r < DONE_BAND) && (prev_err_r > -DONE_BAND);
  end

  always_comb begin
    pe_nxt  = PE_W'(err1_r) * PE_W'($signed({1'b0, kp1_r}));
    pi_nxt  = PI_W'(acc1_r) * PI_W'($signed({1'b0, ki1_r}));
    pd_nxt  = PE_W'(der1_r) * PE_W'($signed({1'b0, kd1_r}));
    sum_nxt = SUM_W'(pe2_r) + SUM_W'(pi2_r) + SUM_W'(pd2_r);
  end

  // divide by 4096 toward zero, cap at max_drive, floor at -32768, zero if zero3_r
  always_comb begin
    sum_adj = sum3_r[SUM_W-1] ? (sum3_r + SUM_W'(4095)) : sum3_r;
    q       = sum_adj[SUM_W-1:12];
    if (zero3_r) begin
      drive_nxt = '0;
    end else if (q > $signed({{(Q_W-MAXD_W){1'b0}}, maxd3_r})) begin
      drive_nxt = DRIVE_W'($signed({1'b0, maxd3_r}));
    end else if (q < -(Q_W'(32768))) begin
      drive_nxt = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_nxt = q[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
      last_r     <= '0;
    end else if (ctl.start) begin
      prev_err_r <= ERR_W'(target);
      integ_r    <= '0;
      last_r     <= '0;
    end else if (ctl.step) begin
      prev_err_r <= err_nxt;
      integ_r    <= acc_nxt;
      last_r     <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      err1_r  <= err_nxt;
      der1_r  <= der_nxt;
      acc1_r  <= acc_nxt[IACC_W-1:0];
      kp1_r   <= kp;
      ki1_r   <= ki;
      kd1_r   <= kd;
      maxd1_r <= max_drive;
      zero1_r <= !ctl.step || dead;
    end
    if (ctl.load2) begin
      pe2_r   <= pe_nxt;
      pi2_r   <= pi_nxt;
      pd2_r   <= pd_nxt;
      maxd2_r <= maxd1_r;
      zero2_r <= zero1_r;
    end
    if (ctl.load3) begin
      sum3_r  <= sum_nxt;
      maxd3_r <= maxd2_r;
      zero3_r <= zero2_r;
    end
    if (ctl.load4) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule
`default_nettype wire

// ===== rtl/core/dual_side_pid_turn_controller_core.sv =====
// two-wheel turn controller, one pid position loop per side
// input channel in_*: in_tuser is the request kind (0 start a turn, 1 control
//   tick), in_tdata carries the left and right encoder counts
// result channel out_*: one item per input item, left/right drive and done flag
// config port cfg_*: write turn_degrees, max_drive and the two gain sets while
//   the block is idle; the targets are worked out when turn_degrees is written
// pipeline: four register stages (loop state update, gain products, sum,
//   divide and cap); out_tvalid is the valid flag of the last stage
// throughput: one item per cycle unless the receiver stalls; the loop state is updated
//   in the accept cycle so the next tick sees it at once
// receiver stall: the four stages hold their items and keep taking input until
//   every stage is full; in_tready then follows out_tready
// reset: all stages empty, config registers at their defaults, turn marked done so
//   ticks before the first start give zero drive with turn_done set
`default_nettype none
module dual_side_pid_turn_controller_core import dspt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [47:0]          in_tdata,  // left_count[23:0], right_count[47:24]
  input  wire logic                 in_tuser,  // req_type
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata, // left_drive[15:0], right_drive[31:16],
                                               // turn_done[32], zero fill
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic signed [TARGET_W-1:0] target_r;
  logic                       wide_r;
  logic [MAXD_W-1:0]          max_drive_r;
  logic [GAIN_W-1:0]          kp_wide_r, ki_wide_r, kd_wide_r;
  logic [GAIN_W-1:0]          kp_narrow_r, ki_narrow_r, kd_narrow_r;

  logic [TICK_W-1:0] tick_r;
  logic              finished_r;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              done1_r, done2_r, done3_r, done4_r;

  logic rdy1, rdy2, rdy3, rdy4;
  logic accept, start, tick, active, finish, step;
  logic small_l, small_r;
  logic [TICK_W-1:0] tick_nxt;
  logic [GAIN_W-1:0] kp, ki, kd;
  logic signed [DRIVE_W-1:0] left_drive, right_drive;
  dspt_ctl_t ctl_l, ctl_r;

  logic signed [DEG_W-1:0] cfg_deg;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_comb begin
    accept   = in_tvalid && rdy1;
    start    = accept && !in_tuser;
    tick     = accept && in_tuser;
    active   = tick && !finished_r;
    tick_nxt = tick_r + TICK_W'(1);
    finish   = (tick_nxt == TICK_LIMIT) || (small_l && small_r);
    step     = active && !finish;
    kp = wide_r ? kp_wide_r : kp_narrow_r;
    ki = wide_r ? ki_wide_r : ki_narrow_r;
    kd = wide_r ? kd_wide_r : kd_narrow_r;
    ctl_l.start = start;
    ctl_l.step  = step;
    ctl_l.load1 = rdy1;
    ctl_l.load2 = rdy2 && v1_r;
    ctl_l.load3 = rdy3 && v2_r;
    ctl_l.load4 = rdy4 && v3_r;
    ctl_r = ctl_l;
    cfg_deg = $signed(cfg_wdata[DEG_W-1:0]);
  end

  dspt_side u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_l),
    .target     (target_r),
    .count      ($signed(in_tdata[23:0])),
    .kp         (kp),
    .ki         (ki),
    .kd         (kd),
    .max_drive  (max_drive_r),
    .prev_small (small_l),
    .drive      (left_drive)
  );

  dspt_side u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_r),
    .target     (-target_r),
    .count      ($signed(in_tdata[47:24])),
    .kp         (kp),
    .ki         (ki),
    .kd         (kd),
    .max_drive  (max_drive_r),
    .prev_small (small_r),
    .drive      (right_drive)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      wide_r      <= 1'b0;
      max_drive_r <= 8'd127;
      kp_wide_r   <= 16'd4096;
      ki_wide_r   <= '0;
      kd_wide_r   <= '0;
      kp_narrow_r <= 16'd1270;
      ki_narrow_r <= '0;
      kd_narrow_r <= '0;
    end else if (cfg_we) begin
      case (dspt_reg_t'(cfg_index))
        REG_TURN_DEGREES: begin
          target_r <= turn_target(cfg_deg);
          wide_r   <= (cfg_deg >= WIDE_TURN);
        end
        REG_MAX_DRIVE: max_drive_r <= cfg_wdata[MAXD_W-1:0];
        REG_KP_WIDE:   kp_wide_r   <= cfg_wdata;
        REG_KI_WIDE:   ki_wide_r   <= cfg_wdata;
        REG_KD_WIDE:   kd_wide_r   <= cfg_wdata;
        REG_KP_NARROW: kp_narrow_r <= cfg_wdata;
        REG_KI_NARROW: ki_narrow_r <= cfg_wdata;
        REG_KD_NARROW: kd_narrow_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      finished_r <= 1'b1;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (start) begin
        tick_r     <= '0;
        finished_r <= 1'b0;
      end else if (active) begin
        tick_r <= tick_nxt;
        if (finish) begin
          finished_r <= 1'b1;
        end
      end
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1)               done1_r <= tick && (finished_r || finish);
    if (rdy2 && v1_r)       done2_r <= done1_r;
    if (rdy3 && v2_r)       done3_r <= done2_r;
    if (rdy4 && v3_r)       done4_r <= done3_r;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'd0, done4_r, right_drive, left_drive};

endmodule
`default_nettype wire
